FILE: sv/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define SFLA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under an active-low reset.
`define SFLA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/sfla_pkg.sv
// Shared constants, types and codes of the sorted free-list allocator.
package sfla_pkg;

    localparam int ARENA_UNITS = 4096;
    localparam int HDR_UNITS   = 2;
    localparam int OFF_W       = 12;
    localparam int LINK_W      = 13;
    localparam int SIZE_W      = 12;
    localparam int REQ_W       = 13;
    localparam int SUM_W       = 14;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(ARENA_UNITS);
    localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(ARENA_UNITS - HDR_UNITS);

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_TOO_BIG  = 2'd2,
        ST_NOT_BUSY = 2'd3
    } t_status;

    typedef struct packed {
        logic              busy;
        logic [LINK_W-1:0] next;
        logic [SIZE_W-1:0] size;
    } t_hdr;

    localparam int HDR_W = $bits(t_hdr);

    typedef struct packed {
        logic             we;
        logic [OFF_W-1:0] waddr;
        t_hdr             wdata;
        logic             re;
        logic [OFF_W-1:0] raddr;
    } t_ram_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AWALK,
        S_ADEC,
        S_APREV,
        S_APICK,
        S_FCHK,
        S_FWALK,
        S_FMRG,
        S_FPREV,
        S_DONE
    } t_state;

endpackage

FILE: sv/sfla_hdr_ram.sv
// Single-port-write, single-port-read header memory with registered read data.
module sfla_hdr_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 26
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

FILE: sv/sorted_free_list_allocator.sv
// Top level: address-ordered free-list allocator with first, best or worst fit.
// An allocate reads free blocks in list order (first fit stops at the hit, best and worst fit
// read the whole list); a free reads its header and walks the list to its place. Oversized, null,
// short-offset or empty-list words go straight to the result; a non-busy free after the header read.
// One word is in work at a time: the next can be taken in the same cycle as the result word appears.
// Reset is synchronous, active low; entry 0 reads as one free block spanning the arena.
module sorted_free_list_allocator
    import sfla_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic [REQ_W-1:0]   i_req_size,
    input  logic [OFF_W-1:0]   i_free_offset,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic [OFF_W-1:0]   o_user_offset,
    output logic [SIZE_W-1:0]  o_granted_size
);
    // Control state.
    t_state            r_state, n_state;
    logic [1:0]        r_policy;
    logic [LINK_W-1:0] r_head, n_head;
    logic              r_e0_init, n_e0_init;
    logic              r_rd_zero, n_rd_zero;
    logic              r_found, n_found;
    logic              r_o_valid, n_o_valid;

    // Walk and working registers.
    logic [REQ_W-1:0]  r_need, n_need;
    logic [LINK_W-1:0] r_cur, n_cur;
    logic [LINK_W-1:0] r_prev, n_prev;
    logic [SIZE_W-1:0] r_prev_size, n_prev_size;
    logic [OFF_W-1:0]  r_pick, n_pick;
    logic [LINK_W-1:0] r_pick_prev, n_pick_prev;
    logic [SIZE_W-1:0] r_pick_prev_size, n_pick_prev_size;
    logic [SIZE_W-1:0] r_pick_size, n_pick_size;
    logic [LINK_W-1:0] r_pick_next, n_pick_next;
    logic [REQ_W-1:0]  r_best, n_best;
    logic [SIZE_W-1:0] r_worst, n_worst;
    logic [LINK_W-1:0] r_link, n_link;
    logic [SIZE_W-1:0] r_given, n_given;
    logic [OFF_W-1:0]  r_blk, n_blk;
    logic [SIZE_W-1:0] r_blk_size, n_blk_size;
    logic [SIZE_W-1:0] r_cur_size, n_cur_size;
    logic [LINK_W-1:0] r_cur_next, n_cur_next;

    // Result staging and output word.
    t_status           r_res_status, n_res_status;
    logic [OFF_W-1:0]  r_res_off, n_res_off;
    logic [SIZE_W-1:0] r_res_size, n_res_size;
    t_status           r_o_status, n_o_status;
    logic [OFF_W-1:0]  r_o_off, n_o_off;
    logic [SIZE_W-1:0] r_o_size, n_o_size;

    t_ram_req          ram_req;
    logic [HDR_W-1:0]  ram_q;
    t_hdr              rd;

    logic              in_acc;
    logic [1:0]        pol;
    logic              fit, take, pol_first;
    logic [REQ_W-1:0]  rem;
    logic [SUM_W-1:0]  split_at;
    logic              do_split;
    logic [SUM_W-1:0]  blk_end, prev_hdr_end;
    logic              n_merge, p_merge;
    logic [REQ_W-1:0]  merged;

    sfla_hdr_ram #(
        .ADDR_W (OFF_W),
        .DATA_W (HDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_q)
    );

    // Entry 0 holds its reset value until the first write to it; other entries are read only once
    // written, except the header that a free of a never-granted offset reads.
    always_comb begin
        if (r_rd_zero) begin
            rd = '{busy: 1'b0, next: NIL_LINK, size: INIT_SIZE};
        end else begin
            rd = t_hdr'(ram_q);
        end
    end

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_ready = (r_state == S_IDLE);
    // Policy code 3 behaves as first fit.
    assign pol        = (r_policy == POL_BEST || r_policy == POL_WORST) ? r_policy : POL_FIRST;
    assign pol_first  = (pol == POL_FIRST);

    assign fit = ({1'b0, rd.size} >= r_need);
    always_comb begin
        unique case (pol)
            POL_BEST:  take = fit && ({1'b0, rd.size} < r_best);
            POL_WORST: take = fit && (rd.size > r_worst);
            default:   take = fit;
        endcase
    end

    // Split of the picked block: the remainder gets its own header when it is larger
    // than one header and that header still lies inside the arena.
    assign rem      = {1'b0, r_pick_size} - r_need;
    assign split_at = SUM_W'(r_pick) + SUM_W'(HDR_UNITS) + SUM_W'(r_need);
    assign do_split = (rem > REQ_W'(HDR_UNITS)) && (split_at < SUM_W'(ARENA_UNITS));

    // Coalescing checks on free.
    assign blk_end      = SUM_W'(r_blk) + SUM_W'(HDR_UNITS) + SUM_W'(r_blk_size);
    assign n_merge      = (r_cur != NIL_LINK) && (blk_end == SUM_W'(r_cur));
    assign merged       = REQ_W'(r_blk_size) + REQ_W'(r_cur_size) + REQ_W'(HDR_UNITS);
    assign prev_hdr_end = SUM_W'(r_prev) + SUM_W'(HDR_UNITS) + SUM_W'(r_prev_size);
    assign p_merge      = (prev_hdr_end == SUM_W'(r_blk));

    always_comb begin
        n_state          = r_state;
        n_head           = r_head;
        n_found          = r_found;
        n_need           = r_need;
        n_cur            = r_cur;
        n_prev           = r_prev;
        n_prev_size      = r_prev_size;
        n_pick           = r_pick;
        n_pick_prev      = r_pick_prev;
        n_pick_prev_size = r_pick_prev_size;
        n_pick_size      = r_pick_size;
        n_pick_next      = r_pick_next;
        n_best           = r_best;
        n_worst          = r_worst;
        n_link           = r_link;
        n_given          = r_given;
        n_blk            = r_blk;
        n_blk_size       = r_blk_size;
        n_cur_size       = r_cur_size;
        n_cur_next       = r_cur_next;
        n_res_status     = r_res_status;
        n_res_off        = r_res_off;
        n_res_size       = r_res_size;
        n_o_status       = r_o_status;
        n_o_off          = r_o_off;
        n_o_size         = r_o_size;
        n_o_valid        = r_o_valid && !i_out_ready;
        ram_req          = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_status = ST_OK;
                    n_res_off    = '0;
                    n_res_size   = '0;
                    n_prev       = NIL_LINK;
                    n_cur        = r_head;
                    if (!i_mode) begin
                        n_need  = i_req_size;
                        n_found = 1'b0;
                        n_best  = REQ_W'(ARENA_UNITS);
                        n_worst = '0;
                        if (i_req_size > REQ_W'(ARENA_UNITS)) begin
                            n_res_status = ST_TOO_BIG;
                            n_state      = S_DONE;
                        end else if (r_head == NIL_LINK) begin
                            n_res_status = ST_NO_FIT;
                            n_state      = S_DONE;
                        end else begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = r_head[OFF_W-1:0];
                            n_state       = S_AWALK;
                        end
                    end else begin
                        if (i_free_offset == '0) begin
                            n_state = S_DONE;
                        end else if (i_free_offset < OFF_W'(HDR_UNITS)) begin
                            n_res_status = ST_NOT_BUSY;
                            n_state      = S_DONE;
                        end else begin
                            n_blk         = i_free_offset - OFF_W'(HDR_UNITS);
                            ram_req.re    = 1'b1;
                            ram_req.raddr = i_free_offset - OFF_W'(HDR_UNITS);
                            n_state       = S_FCHK;
                        end
                    end
                end
            end

            S_AWALK: begin
                if (take) begin
                    n_found          = 1'b1;
                    n_pick           = r_cur[OFF_W-1:0];
                    n_pick_prev      = r_prev;
                    n_pick_prev_size = r_prev_size;
                    n_pick_size      = rd.size;
                    n_pick_next      = rd.next;
                    n_best           = {1'b0, rd.size};
                    n_worst          = rd.size;
                end
                if ((take && pol_first) || rd.next == NIL_LINK) begin
                    n_state = S_ADEC;
                end else begin
                    n_prev        = r_cur;
                    n_prev_size   = rd.size;
                    n_cur         = rd.next;
                    ram_req.re    = 1'b1;
                    ram_req.raddr = rd.next[OFF_W-1:0];
                end
            end

            S_ADEC: begin
                if (!r_found) begin
                    n_res_status = ST_NO_FIT;
                    n_state      = S_DONE;
                end else begin
                    if (do_split) begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = split_at[OFF_W-1:0];
                        ram_req.wdata = '{busy: 1'b0, next: r_pick_next,
                                          size: SIZE_W'(rem - REQ_W'(HDR_UNITS))};
                        n_link        = split_at[LINK_W-1:0];
                        n_given       = r_need[SIZE_W-1:0];
                    end else begin
                        n_link  = r_pick_next;
                        n_given = r_pick_size;
                    end
                    n_state = S_APREV;
                end
            end

            S_APREV: begin
                if (r_pick_prev == NIL_LINK) begin
                    n_head = r_link;
                end else begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = r_pick_prev[OFF_W-1:0];
                    ram_req.wdata = '{busy: 1'b0, next: r_link, size: r_pick_prev_size};
                end
                n_state = S_APICK;
            end

            S_APICK: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_pick;
                ram_req.wdata = '{busy: 1'b1, next: NIL_LINK, size: r_given};
                n_res_status  = ST_OK;
                n_res_off     = r_pick + OFF_W'(HDR_UNITS);
                n_res_size    = r_given;
                n_state       = S_DONE;
            end

            S_FCHK: begin
                if (!rd.busy) begin
                    n_res_status = ST_NOT_BUSY;
                    n_state      = S_DONE;
                end else begin
                    n_blk_size = rd.size;
                    if (r_head != NIL_LINK) begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = r_head[OFF_W-1:0];
                        n_state       = S_FWALK;
                    end else begin
                        n_state = S_FMRG;
                    end
                end
            end

            S_FWALK: begin
                if (r_cur < {1'b0, r_blk}) begin
                    n_prev      = r_cur;
                    n_prev_size = rd.size;
                    n_cur       = rd.next;
                    if (rd.next != NIL_LINK) begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = rd.next[OFF_W-1:0];
                    end else begin
                        n_state = S_FMRG;
                    end
                end else begin
                    n_cur_size = rd.size;
                    n_cur_next = rd.next;
                    n_state    = S_FMRG;
                end
            end

            S_FMRG: begin
                // Merge with the following free block when they touch; r_cur then
                // carries the link that the freed block ends up with.
                ram_req.we    = 1'b1;
                ram_req.waddr = r_blk;
                if (n_merge) begin
                    ram_req.wdata = '{busy: 1'b0, next: r_cur_next, size: merged[SIZE_W-1:0]};
                    n_blk_size    = merged[SIZE_W-1:0];
                    n_cur         = r_cur_next;
                end else begin
                    ram_req.wdata = '{busy: 1'b0, next: r_cur, size: r_blk_size};
                end
                n_state = S_FPREV;
            end

            S_FPREV: begin
                if (r_prev == NIL_LINK) begin
                    n_head = {1'b0, r_blk};
                end else begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = r_prev[OFF_W-1:0];
                    if (p_merge) begin
                        ram_req.wdata = '{busy: 1'b0, next: r_cur,
                                          size: r_prev_size + r_blk_size
                                              + SIZE_W'(HDR_UNITS)};
                    end else begin
                        ram_req.wdata = '{busy: 1'b0, next: {1'b0, r_blk},
                                          size: r_prev_size};
                    end
                end
                n_res_status = ST_OK;
                n_state      = S_DONE;
            end

            S_DONE: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_off    = r_res_off;
                    n_o_size   = r_res_size;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rd_zero = ram_req.re && (ram_req.raddr == '0) && r_e0_init;
        n_e0_init = r_e0_init && !(ram_req.we && ram_req.waddr == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_policy  <= POL_FIRST;
            r_head    <= '0;
            r_e0_init <= 1'b1;
            r_rd_zero <= 1'b0;
            r_found   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_e0_init <= n_e0_init;
            r_rd_zero <= n_rd_zero;
            r_found   <= n_found;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_need           <= n_need;
        r_cur            <= n_cur;
        r_prev           <= n_prev;
        r_prev_size      <= n_prev_size;
        r_pick           <= n_pick;
        r_pick_prev      <= n_pick_prev;
        r_pick_prev_size <= n_pick_prev_size;
        r_pick_size      <= n_pick_size;
        r_pick_next      <= n_pick_next;
        r_best           <= n_best;
        r_worst          <= n_worst;
        r_link           <= n_link;
        r_given          <= n_given;
        r_blk            <= n_blk;
        r_blk_size       <= n_blk_size;
        r_cur_size       <= n_cur_size;
        r_cur_next       <= n_cur_next;
        r_res_status     <= n_res_status;
        r_res_off        <= n_res_off;
        r_res_size       <= n_res_size;
        r_o_status       <= n_o_status;
        r_o_off          <= n_o_off;
        r_o_size         <= n_o_size;
    end

    assign o_out_valid    = r_o_valid;
    assign o_status       = r_o_status;
    assign o_user_offset  = r_o_off;
    assign o_granted_size = r_o_size;
endmodule

FILE: sv/sfla_checker.sv
// Port-level checker for the allocator and its bind to the top level.
`include "assert_macros.svh"

module sfla_checker
    import sfla_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [1:0]        o_status,
    input logic [OFF_W-1:0]  o_user_offset,
    input logic [SIZE_W-1:0] o_granted_size
);
    // A stalled result word stays offered.
    `SFLA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // Failed requests carry neither offset nor size.
    `SFLA_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, o_out_valid && o_status != ST_OK, o_user_offset == '0 && o_granted_size == '0)

    // A granted user area always lies behind a header.
    `SFLA_ASSERT_IMPL(a_off_hdr, i_clk, i_rst_n, o_out_valid && o_user_offset != '0, o_user_offset >= OFF_W'(HDR_UNITS))

    // A free result, or any word without an offset, grants nothing.
    `SFLA_ASSERT_IMPL(a_size_off, i_clk, i_rst_n, o_out_valid && o_user_offset == '0, o_granted_size == '0)
endmodule

bind sorted_free_list_allocator sfla_checker u_sfla_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_user_offset  (o_user_offset),
    .o_granted_size (o_granted_size)
);
